/* src/sha_pkg.sv */
package sha_pkg;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // Front-to-back command: absorb a byte or finish
   typedef struct packed {
      logic       finish;
      logic [7:0] data_byte;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } back_state_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam int         LEN_OFFSET  = 56;
   localparam int         CMD_DEPTH   = 4;
   localparam int         CMD_AW      = $clog2(CMD_DEPTH);

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

/* src/sha_front.sv */
module sha_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sha_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_take,
   output sha_pkg::cmd_type cmd_data
);
   import sha_pkg::*;

   cmd_type             queue_ff [CMD_DEPTH];
   logic [CMD_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CMD_AW:0]     count_ff;
   logic                push_ok, pop_ok;
   cmd_type             cmd_in;

   assign req_full  = (count_ff == (CMD_AW+1)'(CMD_DEPTH));
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign pop_ok    = cmd_valid && cmd_take;
   assign cmd_data  = queue_ff[rd_ptr_ff];

   // Classify: keep the byte only for absorb requests
   always_comb begin
      cmd_in.finish    = (req_data.opcode == OP_FINISH);
      cmd_in.data_byte = (req_data.opcode == OP_FINISH) ? 8'h00 : req_data.data_byte;
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop_ok)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (CMD_AW+1)'(push_ok) - (CMD_AW+1)'(pop_ok);
      end
   end

endmodule

/* src/sha_back.sv */
module sha_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_take,
   input  sha_pkg::cmd_type cmd_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   back_state_type state_ff, state_in;

   // Block buffer as sixteen big-endian words, at most one byte lane written per cycle
   logic [31:0] blk_ff [16];
   logic [31:0] hash_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [5:0]  round_ff;
   logic [5:0]  pad_idx_ff;
   logic        final_ff;
   logic        second_ff;
   logic [2:0]  emit_ff;

   logic        absorb_go, finish_go;
   logic [31:0] t1, t2, s0, s1, w_new, big0, big1, ch, maj;
   logic [7:0]  pad_byte;

   assign absorb_go = (state_ff == ST_FILL) && cmd_valid && !cmd_data.finish;
   assign finish_go = (state_ff == ST_FILL) && cmd_valid && cmd_data.finish;

   // Round logic and rolling message schedule
   always_comb begin
      big1  = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      big0  = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1    = v_ff[7] + big1 + ch + ROUND_K[round_ff] + w_ff[0];
      t2    = big0 + maj;
      s0    = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1    = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
   end

   // Padding byte for position pad_idx_ff: marker, zeros, then length (in a second block if it does not fit)
   always_comb begin
      pad_byte = 8'h00;
      if (pad_idx_ff == fill_ff && !second_ff) begin
         pad_byte = PAD_BYTE;
      end else if (pad_idx_ff >= 6'(LEN_OFFSET) && !(fill_ff >= 6'(LEN_OFFSET) && !second_ff)) begin
         pad_byte = bits_ff[8*(7 - pad_idx_ff[2:0]) +: 8];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL:  begin
            if (absorb_go && fill_ff == 6'd63) state_in = ST_LOAD;
            else if (finish_go)                state_in = ST_PAD;
         end
         ST_PAD:   if (pad_idx_ff == 6'd63) state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_ROUND;
         ST_ROUND: if (round_ff == 6'd63) state_in = ST_ADD;
         ST_ADD: begin
            if (!final_ff)                          state_in = ST_FILL;
            else if (!second_ff && fill_ff >= 6'(LEN_OFFSET)) state_in = ST_PAD;
            else                                    state_in = ST_EMIT;
         end
         ST_EMIT:  if (rsp_pop && emit_ff == 3'd7) state_in = ST_FILL;
         default:  state_in = ST_FILL;
      endcase
   end

   always_comb begin
      cmd_take  = 1'b0;
      rsp_empty = 1'b1;
      unique case (state_ff)
         ST_FILL: cmd_take  = 1'b1;
         ST_EMIT: rsp_empty = 1'b0;
         default: ;
      endcase
      rsp_data.digest_word = hash_ff[emit_ff];
      rsp_data.word_index  = emit_ff;
      rsp_data.last_word   = (emit_ff == 3'd7);
   end

   // Block buffer and working registers, no reset
   always_ff @(posedge clock) begin
      if (absorb_go) begin
         blk_ff[fill_ff[5:2]][8*(3 - fill_ff[1:0]) +: 8] <= cmd_data.data_byte;
      end
      if (state_ff == ST_PAD) begin
         blk_ff[pad_idx_ff[5:2]][8*(3 - pad_idx_ff[1:0]) +: 8] <= pad_byte;
      end
      if (state_ff == ST_LOAD) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= hash_ff[i];
         for (int i = 0; i < 16; i++) w_ff[i] <= blk_ff[i];
      end else if (state_ff == ST_ROUND) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         fill_ff    <= '0;
         bits_ff    <= '0;
         round_ff   <= '0;
         pad_idx_ff <= '0;
         final_ff   <= 1'b0;
         second_ff  <= 1'b0;
         emit_ff    <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= INIT_HASH[i];
      end else begin
         state_ff <= state_in;
         if (absorb_go) begin
            fill_ff <= fill_ff + 1'b1;
            if (fill_ff == 6'd63) bits_ff <= bits_ff + 64'd512;
         end
         if (finish_go) begin
            final_ff   <= 1'b1;
            second_ff  <= 1'b0;
            pad_idx_ff <= fill_ff;
            bits_ff    <= bits_ff + {55'd0, fill_ff, 3'd0};
         end
         if (state_ff == ST_PAD) pad_idx_ff <= pad_idx_ff + 1'b1;
         if (state_ff == ST_ROUND) round_ff <= round_ff + 1'b1;
         if (state_ff == ST_ADD) begin
            for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + v_ff[i];
            if (final_ff && !second_ff && fill_ff >= 6'(LEN_OFFSET)) begin
               second_ff  <= 1'b1;
               pad_idx_ff <= '0;
            end
         end
         if (state_ff == ST_EMIT && rsp_pop) begin
            emit_ff <= emit_ff + 1'b1;
            if (emit_ff == 3'd7) begin
               final_ff  <= 1'b0;
               second_ff <= 1'b0;
               fill_ff   <= '0;
               bits_ff   <= '0;
               for (int i = 0; i < 8; i++) hash_ff[i] <= INIT_HASH[i];
            end
         end
      end
   end

endmodule

/* src/sha256_stream_hasher.sv */
// SHA-256 hasher, one message byte per request.
// Request channel: req_push / req_full with req_data (opcode, data_byte).
//   opcode absorb adds data_byte to the message; opcode finish pads the
//   message and produces the digest.
// Response channel: rsp_empty / rsp_pop with rsp_data; a finish yields eight
//   responses, word_index 0..7, last_word set on the eighth.
// A four-entry command queue separates request intake from the hash engine.
// Absorb writes each byte into the block buffer; every 64th byte adds a
// compression (load, 64 rounds one per cycle, add), during which no bytes
// are taken. Finish pads the rest of the block with marker, zeros and length
// and compresses it; with 56 or more bytes pending the length goes into a
// second padded block and compression. Then the eight words follow back to back.
// While the receiver stalls, the engine holds the digest and stops taking
// commands; requests fill the queue and then req_full rises.
// Synchronous reset clears the queue and returns the chaining state to the
// standard initial value, with no message pending. After the last digest
// word is popped the state returns to the initial value as well.
module sha256_stream_hasher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sha_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   logic    cmd_valid, cmd_take;
   cmd_type cmd_data;

   sha_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .cmd_valid, .cmd_take, .cmd_data
   );

   sha_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .rsp_empty, .rsp_pop, .rsp_data
   );

endmodule

/* src/sha_checker.sv */
module sha_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   // Word index advances by one on each pop within a digest
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last_word) |=>
         (!rsp_empty && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
      else $error("digest word index skipped");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.last_word == (rsp_data.word_index == 3'd7)))
      else $error("last_word mismatch");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_data.last_word) |=> rsp_empty)
      else $error("response after last word");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("not idle after reset");

endmodule

bind sha256_stream_hasher sha_checker u_checker (
   .clock, .reset, .req_full, .rsp_empty, .rsp_pop, .rsp_data
);
